// ----- rtl/swtq_pkg.sv -----
package swtq_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int WAKE_W       = 32;
    localparam int SECS_W       = 12;
    localparam int PSLOT_W      = 4;

    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    localparam logic KIND_SLEEP = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic ACT_SLEEP  = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [1:0] STATUS_QUEUED  = 2'd0;
    localparam logic [1:0] STATUS_BAD_DUR = 2'd1;
    localparam logic [1:0] STATUS_DUP     = 2'd2;

endpackage

// ----- rtl/swtq_ram.sv -----
module swtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sleep_wake_timer_queue_unit.sv -----
// Sleep queue of process slots kept in wake-time order as a linked list held in two small
// RAMs (wake time and next link per slot). A sleep beat (tuser 0) asks that a slot sleep
// for a number of seconds from now; it gets one status beat back: queued, bad duration
// (zero or negative) or slot already queued. The wake time is now + seconds * 1e6 us,
// saturating at 32'hffffffff, and equal wake times keep arrival order. A tick beat
// (tuser 1) carries the current time and gets one beat per woken slot in wake order,
// tlast on the final one, or a single beat with woke_valid low when nothing is due; at
// most 16 slots wake per tick. One item is handled at a time: no new beat is taken until
// the closing result beat of the item before has gone out. The insert walk visits at most
// SLOTS queued entries. Both walks go through the single read port of the list RAMs and
// one shared wake-time comparator, each entry in two steps (read, then compare), and each
// woken slot also takes its own output beat, which the receiver can stall.
module sleep_wake_timer_queue_unit #(
    parameter int SLOTS = swtq_pkg::SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // proc_slot[3:0], seconds[15:4], now[47:16]
    input  logic [swtq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], woke_valid[2], woken_slot[6:3], zero[7]
    output logic [swtq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    import swtq_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CHECK    = 4'd1;
    localparam logic [3:0] ST_MUL      = 4'd2;
    localparam logic [3:0] ST_SUM      = 4'd3;
    localparam logic [3:0] ST_WALK_RD  = 4'd4;
    localparam logic [3:0] ST_WALK_CMP = 4'd5;
    localparam logic [3:0] ST_INS_SELF = 4'd6;
    localparam logic [3:0] ST_INS_PREV = 4'd7;
    localparam logic [3:0] ST_POP_RD   = 4'd8;
    localparam logic [3:0] ST_POP_CMP  = 4'd9;
    localparam logic [3:0] ST_EMIT_MID = 4'd10;
    localparam logic [3:0] ST_EMIT_END = 4'd11;

    // proc_slot modulo SLOTS as a running count over the sixteen codes
    function automatic logic [SLOT_W-1:0] slot_of(input logic [PSLOT_W-1:0] v);
        logic [LINK_W-1:0] r;
        logic [SLOT_W-1:0] res;
        r   = '0;
        res = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (PSLOT_W'(k) == v)
            begin
                res = r[SLOT_W-1:0];
            end
            if (r == LINK_W'(SLOTS - 1))
            begin
                r = '0;
            end
            else
            begin
                r = r + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [LINK_W-1:0] clamp_link(input logic [LINK_W-1:0] l);
        return (l < NULL_LINK) ? l : NULL_LINK;
    endfunction

    logic [3:0]           state_reg, state_next;
    logic                 act_reg, act_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic signed [SECS_W-1:0] secs_reg, secs_next;
    logic [WAKE_W-1:0]    key_reg, key_next;
    logic [30:0]          prod_reg, prod_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic [LINK_W-1:0]    prev_reg, prev_next;
    logic [LINK_W-1:0]    steps_reg, steps_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [SLOTS-1:0]     queued_reg, queued_next;

    logic                 out_kind_reg, out_kind_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic                 out_woke_reg, out_woke_next;
    logic [PSLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                 out_last_reg, out_last_next;

    logic                 wake_we;
    logic                 link_we;
    logic [SLOT_W-1:0]    link_waddr;
    logic [LINK_W-1:0]    link_wdata;
    logic [SLOT_W-1:0]    raddr;
    logic [WAKE_W-1:0]    wake_rdata;
    logic [LINK_W-1:0]    link_rdata;
    logic                 cmp_le;
    logic [WAKE_W:0]      sum;
    logic                 in_beat;
    logic                 fin;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // the one wake-time comparator shared by insert walk and tick pops
    assign cmp_le = (wake_rdata <= key_reg);
    assign sum    = {1'b0, key_reg} + {2'b0, prod_reg};

    assign raddr = (state_reg == ST_WALK_RD) ? cur_reg[SLOT_W-1:0] : head_reg[SLOT_W-1:0];

    assign wake_we    = (state_reg == ST_INS_SELF);
    assign link_we    = (state_reg == ST_INS_SELF) || (state_reg == ST_INS_PREV);
    assign link_waddr = (state_reg == ST_INS_SELF) ? slot_reg : prev_reg[SLOT_W-1:0];
    assign link_wdata = (state_reg == ST_INS_SELF) ? cur_reg : LINK_W'(slot_reg);

    swtq_ram #(
        .WIDTH (WAKE_W),
        .DEPTH (SLOTS)
    ) u_wake_ram (
        .clk   (clk),
        .we    (wake_we),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (wake_rdata)
    );

    swtq_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        slot_next       = slot_reg;
        secs_next       = secs_reg;
        key_next        = key_reg;
        prod_next       = prod_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_slot_next  = pend_slot_reg;
        queued_next     = queued_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_woke_next   = out_woke_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        fin             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    act_next   = s_axis_tuser;
                    slot_next  = slot_of(s_axis_tdata[3:0]);
                    secs_next  = s_axis_tdata[15:4];
                    key_next   = s_axis_tdata[47:16];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (act_reg == ACT_TICK)
                begin
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_POP_RD;
                end
                else
                begin
                    out_kind_next = KIND_SLEEP;
                    out_woke_next = 1'b0;
                    out_slot_next = '0;
                    out_last_next = 1'b1;
                    if (secs_reg <= 12'sd0)
                    begin
                        out_status_next = STATUS_BAD_DUR;
                        state_next      = ST_EMIT_END;
                    end
                    else if (queued_reg[slot_reg])
                    begin
                        out_status_next = STATUS_DUP;
                        state_next      = ST_EMIT_END;
                    end
                    else
                    begin
                        out_status_next = STATUS_QUEUED;
                        state_next      = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = 31'(secs_reg[SECS_W-2:0]) * 31'(USEC_PER_SEC);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                key_next   = sum[WAKE_W] ? '1 : sum[WAKE_W-1:0];
                prev_next  = NULL_LINK;
                cur_next   = head_reg;
                steps_next = '0;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                if ((cur_reg < NULL_LINK) && (steps_reg < NULL_LINK))
                begin
                    state_next = ST_WALK_CMP;
                end
                else
                begin
                    cur_next   = clamp_link(cur_reg);
                    state_next = ST_INS_SELF;
                end
            end
            ST_WALK_CMP:
            begin
                if (cmp_le)
                begin
                    prev_next  = cur_reg;
                    cur_next   = clamp_link(link_rdata);
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_INS_SELF;
                end
            end
            ST_INS_SELF:
            begin
                queued_next[slot_reg] = 1'b1;
                if (prev_reg < NULL_LINK)
                begin
                    state_next = ST_INS_PREV;
                end
                else
                begin
                    head_next  = LINK_W'(slot_reg);
                    state_next = ST_EMIT_END;
                end
            end
            ST_INS_PREV:
            begin
                state_next = ST_EMIT_END;
            end
            ST_POP_RD:
            begin
                if ((cnt_reg < CNT_W'(MAX_RESULTS)) && (head_reg < NULL_LINK))
                begin
                    state_next = ST_POP_CMP;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            ST_POP_CMP:
            begin
                if (cmp_le)
                begin
                    queued_next[head_reg[SLOT_W-1:0]] = 1'b0;
                    head_next      = clamp_link(link_rdata);
                    cnt_next       = cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = head_reg[SLOT_W-1:0];
                    // the held slot goes out now that another one is due
                    if (pend_reg)
                    begin
                        out_kind_next   = KIND_TICK;
                        out_status_next = STATUS_QUEUED;
                        out_woke_next   = 1'b1;
                        out_slot_next   = PSLOT_W'(pend_slot_reg);
                        out_last_next   = 1'b0;
                        state_next      = ST_EMIT_MID;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            ST_EMIT_MID:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_EMIT_END:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // closing beat of a tick
        if (fin)
        begin
            out_kind_next   = KIND_TICK;
            out_status_next = STATUS_QUEUED;
            out_woke_next   = pend_reg;
            out_slot_next   = pend_reg ? PSLOT_W'(pend_slot_reg) : '0;
            out_last_next   = 1'b1;
            state_next      = ST_EMIT_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= NULL_LINK;
            queued_reg <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            queued_reg <= queued_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        slot_reg       <= slot_next;
        secs_reg       <= secs_next;
        key_reg        <= key_next;
        prod_reg       <= prod_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        pend_slot_reg  <= pend_slot_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_woke_reg   <= out_woke_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT_MID) || (state_reg == ST_EMIT_END);
    assign m_axis_tdata  = {1'b0, out_slot_reg, out_woke_reg, out_status_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- rtl/swtq_check.sv -----
module swtq_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [swtq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [swtq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tlast
);

    import swtq_pkg::*;

    // one item in flight: never take a beat while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    // a sleep answer is a single beat with no woken slot
    a_sleep_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SLEEP) |->
            (m_axis_tlast && m_axis_tdata[7:2] == 6'd0))
        else $error("malformed sleep result");

    // a tick beat that wakes nothing closes the tick, with status queued and a zero slot field
    a_tick_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_TICK && !m_axis_tdata[2]) |->
            (m_axis_tlast && m_axis_tdata[1:0] == STATUS_QUEUED
             && m_axis_tdata[6:3] == 4'd0))
        else $error("empty tick result not final");

    // after the closing beat goes the block is ready again next cycle
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after final result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

endmodule

bind sleep_wake_timer_queue_unit swtq_check u_swtq_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/tb_sleep_wake_timer_queue_unit.sv -----
module tb_sleep_wake_timer_queue_unit;

    import swtq_pkg::*;

    localparam int NSLOT = SLOTS_DEF;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic       woke_valid;
        logic [3:0] woken_slot;
        logic       last;
    } result_t;

    typedef struct packed {
        logic               act;
        logic [3:0]         slot;
        logic signed [11:0] secs;
        logic [31:0]        now;
        logic               typed;
        result_t            res;
    } stim_row_t;

    localparam result_t NONE_DUE  = '{KIND_TICK, 2'd0, 1'b0, 4'd0, 1'b1};
    localparam result_t SLEPT     = '{KIND_SLEEP, STATUS_QUEUED, 1'b0, 4'd0, 1'b1};
    localparam result_t BAD_DUR   = '{KIND_SLEEP, STATUS_BAD_DUR, 1'b0, 4'd0, 1'b1};
    localparam result_t DUPLICATE = '{KIND_SLEEP, STATUS_DUP, 1'b0, 4'd0, 1'b1};

    localparam stim_row_t DIRECTED [17] = '{
        '{ACT_TICK,  4'd0,  12'sd0,    32'd0,          1'b1, NONE_DUE},
        '{ACT_SLEEP, 4'd0,  12'sd0,    32'd0,          1'b1, BAD_DUR},
        // most negative duration
        '{ACT_SLEEP, 4'd15, 12'sh800,  32'h1234_5678,  1'b1, BAD_DUR},
        '{ACT_SLEEP, 4'd1,  -12'sd1,   32'd0,          1'b1, BAD_DUR},
        '{ACT_SLEEP, 4'd0,  12'sd1,    32'd0,          1'b1, SLEPT},
        '{ACT_SLEEP, 4'd0,  12'sd2047, 32'd0,          1'b1, DUPLICATE},
        // saturates at the top of the time range
        '{ACT_SLEEP, 4'd15, 12'sd2047, 32'hffff_ffff,  1'b1, SLEPT},
        '{ACT_SLEEP, 4'd2,  12'sd2047, 32'hf000_0000,  1'b0, '0},
        // equal wake times keep arrival order
        '{ACT_SLEEP, 4'd3,  12'sd1,    32'd0,          1'b0, '0},
        '{ACT_SLEEP, 4'd4,  12'sd1,    32'd0,          1'b0, '0},
        '{ACT_SLEEP, 4'd5,  12'sd3,    32'd10,         1'b0, '0},
        '{ACT_SLEEP, 4'd6,  12'sd2047, 32'd0,          1'b0, '0},
        '{ACT_TICK,  4'd0,  12'sd0,    32'd999_999,    1'b1, NONE_DUE},
        '{ACT_TICK,  4'd9,  12'sd5,    32'd1_000_000,  1'b0, '0},
        '{ACT_TICK,  4'd0,  12'sd0,    32'd3_000_009,  1'b0, '0},
        '{ACT_TICK,  4'd0,  12'sd0,    32'hffff_fffe,  1'b0, '0},
        '{ACT_TICK,  4'd0,  12'sd0,    32'hffff_ffff,  1'b0, '0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // shadow of the sleep queue
    logic [31:0] wake_time [NSLOT];
    int          link_to [NSLOT];
    logic        queued [NSLOT];
    int          first_link;

    result_t     fresh[$];
    result_t     pending[$];
    int          mismatch_count = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    bit          hold_go = 1'b0;
    int          hold_left = 0;
    logic [31:0] wall_us;

    sleep_wake_timer_queue_unit #(
        .SLOTS(NSLOT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("sleep_wake_timer_queue_unit verification failed");
        $finish;
    end

    // works out the beats one item gives and updates the shadow queue
    function automatic void predict_beats(input logic act, input logic [3:0] slot,
                                          input logic [11:0] secs, input logic [31:0] now);
        logic [63:0] sum;
        logic [31:0] wake;
        int          prev;
        int          cur;
        int          steps;
        result_t     r;
        fresh.delete();
        if (act == ACT_SLEEP)
        begin
            r = SLEPT;
            if (secs == 12'd0 || secs[11])
                r.status = STATUS_BAD_DUR;
            else if (queued[slot])
                r.status = STATUS_DUP;
            else
            begin
                sum = 64'(now) + 64'(secs) * 64'(USEC_PER_SEC);
                wake = (sum > 64'hffff_ffff) ? 32'hffff_ffff : sum[31:0];
                prev = NSLOT;
                cur = first_link;
                steps = 0;
                while (cur < NSLOT && steps < NSLOT && wake_time[cur] <= wake)
                begin
                    prev = cur;
                    cur = link_to[cur];
                    steps++;
                end
                wake_time[slot] = wake;
                link_to[slot] = cur;
                queued[slot] = 1'b1;
                if (prev < NSLOT)
                    link_to[prev] = int'(slot);
                else
                    first_link = int'(slot);
            end
            fresh.push_back(r);
        end
        else
        begin
            while (fresh.size() < MAX_RESULTS && first_link < NSLOT
                   && wake_time[first_link] <= now)
            begin
                r = '{KIND_TICK, 2'd0, 1'b1, 4'(first_link), 1'b0};
                queued[first_link] = 1'b0;
                first_link = link_to[first_link];
                fresh.push_back(r);
            end
            if (fresh.size() == 0)
                fresh.push_back(NONE_DUE);
            else
            begin
                r = fresh.pop_back();
                r.last = 1'b1;
                fresh.push_back(r);
            end
        end
    endfunction

    task automatic offer_item(input logic act, input logic [3:0] slot, input logic [11:0] secs,
                              input logic [31:0] now, input logic typed, input result_t res);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {now, secs, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_beats(act, slot, secs, now);
        if (typed)
            pending.push_back(res);
        else
            foreach (fresh[k])
                pending.push_back(fresh[k]);
    endtask

    task automatic random_item();
        logic [3:0]  slot;
        logic [11:0] secs;
        logic [31:0] now;
        logic        act;
        int          pick;
        int          step_us;
        pick = $urandom_range(99);
        slot = 4'($urandom_range(15));
        act  = ACT_SLEEP;
        if (pick < 6)
        begin
            // raw noise
            secs = 12'($urandom);
            now  = $urandom;
        end
        else if (pick < 60)
        begin
            repeat (4)
                if (queued[slot])
                    slot = 4'($urandom_range(15));
            secs = ($urandom_range(9) == 0) ? 12'($urandom_range(2047, 1))
                                            : 12'($urandom_range(6, 1));
            now = wall_us + $urandom_range(999);
        end
        else if (pick < 66)
        begin
            secs = 12'(0 - $urandom_range(2048));
            now  = wall_us;
        end
        else
        begin
            act  = ACT_TICK;
            secs = 12'($urandom);
            if (pick < 95)
            begin
                step_us = $urandom_range(3_000_000);
                if (64'(wall_us) + 64'(step_us) > 64'hffff_ffff)
                begin
                    // clock ran off the top: flush and start low again
                    now = 32'hffff_ffff;
                    wall_us = $urandom_range(32'h0fff_ffff);
                end
                else
                begin
                    wall_us = wall_us + step_us;
                    now = wall_us;
                end
            end
            else
                now = $urandom;
        end
        offer_item(act, slot, secs, now, 1'b0, '0);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (hold_go)
        begin
            hold_left = 500;
            hold_go = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending.size() == 0)
            begin
                $error("result beat with no result due");
                mismatch_count++;
            end
            else
            begin
                want = pending.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
                check_field("woke_valid", 32'(want.woke_valid), 32'(m_axis_tdata[2]));
                check_field("woken_slot", 32'(want.woken_slot), 32'(m_axis_tdata[6:3]));
                check_field("pad", 32'd0, 32'(m_axis_tdata[7]));
                check_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    initial
    begin
        for (int s = 0; s < NSLOT; s++)
        begin
            queued[s] = 1'b0;
            wake_time[s] = '0;
            link_to[s] = NSLOT;
        end
        first_link = NSLOT;
        wall_us = $urandom;
        src_idle_pct = 30;
        snk_idle_pct = 68;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
            offer_item(DIRECTED[i].act, DIRECTED[i].slot, DIRECTED[i].secs, DIRECTED[i].now,
                       DIRECTED[i].typed, DIRECTED[i].res);
        repeat (130) random_item();
        drain_results();

        src_idle_pct = 68;
        snk_idle_pct = 30;
        repeat (130) random_item();
        drain_results();

        // receiver holds off while the sender keeps pushing, so the input backs up
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_go = 1'b1;
        repeat (140) random_item();
        drain_results();

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("sleep_wake_timer_queue_unit verification clean");
        else
            $display("sleep_wake_timer_queue_unit verification failed");
        $finish;
    end

endmodule
